### src/imu_fifo_fsync_interpolator_core_macros.svh
// Assertion macros for the IMU FIFO frame-sync interpolator core.
// Used by the port-level checker; no other dependencies.
`ifndef IMU_FIFO_FSYNC_INTERPOLATOR_CORE_MACROS_SVH
`define IMU_FIFO_FSYNC_INTERPOLATOR_CORE_MACROS_SVH

// Check cons in the same cycle as ante, outside reset.
`define IFSI_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante, outside reset.
`define IFSI_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/ifsi_pkg.sv
// Shared types and constants of the IMU FIFO frame-sync interpolator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ifsi_pkg;

    localparam int CH_N      = 6;
    localparam int CH_IDX_W  = 3;
    localparam int SAMPLE_W  = 16;
    localparam int STAMP_W   = 16;
    localparam int F_W       = STAMP_W + 1;
    localparam int TIME_W    = 63;
    localparam int HDR_W     = 8;
    localparam int GAIN_W    = 24;
    localparam int VAL_W     = 32;
    localparam int KIND_W    = 2;

    // shared multiplier operands and product
    localparam int MUL_A_W   = 33;
    localparam int MUL_B_W   = 28;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;

    // numerator a*d + f*b, its magnitude, and magnitude times gain
    localparam int NUM_W     = 34;
    localparam int MAG_W     = 32;
    localparam int DVD_W     = MAG_W + GAIN_W;
    localparam int DIV_CNT_W = $clog2(DVD_W);

    localparam int FRAC_DROP = 8;
    localparam int K_W       = 27;
    localparam logic [K_W-1:0] DEG2RAD_Q32 = 27'd74961321;

    localparam logic [CH_IDX_W-1:0] CH_GYRO_FIRST = 3'd3;
    localparam logic [CH_IDX_W-1:0] CH_LAST       = 3'd5;

    localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;

    localparam logic [HDR_W-1:0] HDR_NORMAL = 8'h68;
    localparam logic [HDR_W-1:0] HDR_FSYNC  = 8'h6C;

    localparam logic [KIND_W-1:0] KIND_RAW_NORMAL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RAW_FSYNC  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FRAME      = 2'd2;

    // APB register file
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;
    localparam int REG_IDX_LSB = 2;
    localparam int REG_IDX_W   = APB_ADDR_W - REG_IDX_LSB;
    localparam logic [REG_IDX_W-1:0] REG_RAW_MODE   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_ACCEL_GAIN = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_GYRO_GAIN  = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_PERIOD     = 2'd3;

    localparam logic [GAIN_W-1:0]  RST_ACCEL_GAIN = 24'd2048;
    localparam logic [GAIN_W-1:0]  RST_GYRO_GAIN  = 24'd512008;
    localparam logic [STAMP_W-1:0] RST_PERIOD     = 16'd5000;

    // stream payload layout
    localparam int S_TDATA_W   = 184;
    localparam int S_CAM_LSB   = 0;
    localparam int S_HDR_LSB   = S_CAM_LSB + TIME_W;
    localparam int S_SMP_LSB   = S_HDR_LSB + HDR_W;
    localparam int S_STAMP_LSB = S_SMP_LSB + CH_N * SAMPLE_W;
    localparam int M_TDATA_W   = 256;
    localparam int M_TIME_LSB  = 0;
    localparam int M_VAL_LSB   = M_TIME_LSB + TIME_W;

    typedef struct packed {
        logic                raw_mode;
        logic [GAIN_W-1:0]   accel_gain;
        logic [GAIN_W-1:0]   gyro_gain;
        logic [STAMP_W-1:0]  sample_period;
    } cfg_t;

    // sample[0..2] accel x/y/z, sample[3..5] rate x/y/z
    typedef struct packed {
        logic                          frame_start;
        logic [TIME_W-1:0]             camera_time;
        logic [HDR_W-1:0]              header;
        logic [CH_N-1:0][SAMPLE_W-1:0] sample;
        logic [STAMP_W-1:0]            stamp;
    } packet_t;

    typedef struct packed {
        logic [KIND_W-1:0]          kind;
        logic [TIME_W-1:0]          time_out;
        logic [CH_N-1:0][VAL_W-1:0] value;
    } result_t;

endpackage

`default_nettype wire

### src/imu_fifo_fsync_interpolator_core.sv
// IMU FIFO packet scaler and frame-sync interpolator, top level.
// Normal packets in frame mode and ignored headers give no result; raw-mode packets and FSYNC
// packets in frame mode reach m_tvalid once the six channels are worked in turn, in frame mode
// each with a pass of the bit-serial divider plus setup. No new packet is taken until the last
// result has moved to the output register; the shared multiplier and divider serve one packet
// at a time. aresetn (synchronous, low) restores register defaults and zeroes stored samples.
`timescale 1ns / 1ps
`default_nettype none

module imu_fifo_fsync_interpolator_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input packets
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // camera_time[62:0], header[70:63], accel_x/y/z[118:71], rate_x/y/z[166:119],
    // stamp_or_delta[182:167], zero pad[183]
    input  logic [ifsi_pkg::S_TDATA_W-1:0]  s_tdata,
    // frame_start
    input  logic                            s_tuser,
    // results
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // time_out[62:0], out_ax/ay/az[158:63], out_gx/gy/gz[254:159], zero pad[255]
    output logic [ifsi_pkg::M_TDATA_W-1:0]  m_tdata,
    // kind
    output logic [ifsi_pkg::KIND_W-1:0]     m_tuser,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ifsi_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ifsi_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ifsi_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import ifsi_pkg::*;

    cfg_t                      cfg;
    packet_t                   in_pkt;
    result_t                   res;
    result_t                   out_reg;
    logic                      m_tvalid_reg;
    logic                      res_valid;
    logic                      res_take;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic                      div_start;
    logic [DVD_W-1:0]          div_dividend;
    logic [STAMP_W-1:0]        div_divisor;
    logic                      div_done;
    logic [DVD_W-1:0]          div_quot;

    // Unpack the input transfer into packet fields.
    always_comb begin
        in_pkt.frame_start = s_tuser;
        in_pkt.camera_time = s_tdata[S_CAM_LSB +: TIME_W];
        in_pkt.header      = s_tdata[S_HDR_LSB +: HDR_W];
        for (int i = 0; i < CH_N; i++) begin
            in_pkt.sample[i] = s_tdata[S_SMP_LSB + i * SAMPLE_W +: SAMPLE_W];
        end
        in_pkt.stamp = s_tdata[S_STAMP_LSB +: STAMP_W];
    end

    ifsi_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // One multiplier serves the numerator, the gain and the deg-to-rad steps.
    ifsi_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // Division by the sample period, one quotient bit per cycle.
    ifsi_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    ifsi_engine u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_pkt       (in_pkt),
        .mul_a        (mul_a),
        .mul_b        (mul_b),
        .prod         (prod),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_done     (div_done),
        .div_quot     (div_quot),
        .res_valid    (res_valid),
        .res_take     (res_take),
        .res          (res)
    );

    // Output register: take a finished result whenever the slot is empty or
    // being drained this cycle, so the engine can start the next packet while a
    // result waits; hold payload while the downstream stalls.
    assign res_take = res_valid && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_take) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_take) begin
            out_reg <= res;
        end
    end

    // Pack the result transfer; the top bit stays zero.
    always_comb begin
        m_tdata = '0;
        m_tdata[M_TIME_LSB +: TIME_W] = out_reg.time_out;
        for (int i = 0; i < CH_N; i++) begin
            m_tdata[M_VAL_LSB + i * VAL_W +: VAL_W] = out_reg.value[i];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.kind;

endmodule

`default_nettype wire

### src/ifsi_cfg_regs.sv
// APB register file of the IMU FIFO frame-sync interpolator.
// Depends on ifsi_pkg for register indexes, reset values and cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module ifsi_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ifsi_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ifsi_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ifsi_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output ifsi_pkg::cfg_t                  cfg
);
    import ifsi_pkg::*;

    logic                   raw_mode_reg;
    logic [GAIN_W-1:0]      accel_gain_reg;
    logic [GAIN_W-1:0]      gyro_gain_reg;
    logic [STAMP_W-1:0]     period_reg;
    logic                   wr_en;
    logic [REG_IDX_W-1:0]   reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[APB_ADDR_W-1:REG_IDX_LSB];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_mode_reg   <= 1'b0;
            accel_gain_reg <= RST_ACCEL_GAIN;
            gyro_gain_reg  <= RST_GYRO_GAIN;
            period_reg     <= RST_PERIOD;
        end else if (wr_en) begin
            case (reg_idx)
                REG_RAW_MODE:   raw_mode_reg   <= pwdata[0];
                REG_ACCEL_GAIN: accel_gain_reg <= pwdata[GAIN_W-1:0];
                REG_GYRO_GAIN:  gyro_gain_reg  <= pwdata[GAIN_W-1:0];
                REG_PERIOD:     period_reg     <= pwdata[STAMP_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_RAW_MODE:   prdata = {{(APB_DATA_W-1){1'b0}}, raw_mode_reg};
            REG_ACCEL_GAIN: prdata = {{(APB_DATA_W-GAIN_W){1'b0}}, accel_gain_reg};
            REG_GYRO_GAIN:  prdata = {{(APB_DATA_W-GAIN_W){1'b0}}, gyro_gain_reg};
            REG_PERIOD:     prdata = {{(APB_DATA_W-STAMP_W){1'b0}}, period_reg};
            default:        prdata = '0;
        endcase
    end

    assign cfg.raw_mode      = raw_mode_reg;
    assign cfg.accel_gain    = accel_gain_reg;
    assign cfg.gyro_gain     = gyro_gain_reg;
    assign cfg.sample_period = period_reg;

endmodule

`default_nettype wire

### src/ifsi_mul.sv
// Shared signed multiplier with a registered product.
// Depends on ifsi_pkg for operand and product widths.
`timescale 1ns / 1ps
`default_nettype none

module ifsi_mul (
    input  logic                                aclk,
    input  logic signed [ifsi_pkg::MUL_A_W-1:0] op_a,
    input  logic signed [ifsi_pkg::MUL_B_W-1:0] op_b,
    output logic signed [ifsi_pkg::PROD_W-1:0]  prod
);
    import ifsi_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

### src/ifsi_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on ifsi_pkg for dividend, divisor and counter widths.
`timescale 1ns / 1ps
`default_nettype none

module ifsi_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [ifsi_pkg::DVD_W-1:0]    dividend,
    input  logic [ifsi_pkg::STAMP_W-1:0]  divisor,
    output logic                          done,
    output logic [ifsi_pkg::DVD_W-1:0]    quotient
);
    import ifsi_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0]     dvd_reg;
    logic [STAMP_W-1:0]   rem_reg;
    logic [STAMP_W-1:0]   dsr_reg;
    logic [STAMP_W:0]     trial;
    logic [STAMP_W:0]     diff;
    logic                 q_bit;

    always_comb begin
        trial = {rem_reg, dvd_reg[DVD_W-1]};
        diff  = trial - {1'b0, dsr_reg};
        q_bit = (trial >= {1'b0, dsr_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // quotient bits shift in from the bottom as the dividend shifts out
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], q_bit};
            rem_reg <= q_bit ? diff[STAMP_W-1:0] : trial[STAMP_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

`default_nettype wire

### src/ifsi_engine.sv
// Sequencer and datapath registers of the frame-sync interpolator.
// Depends on ifsi_pkg; drives the shared ifsi_mul and ifsi_div units.
`timescale 1ns / 1ps
`default_nettype none

module ifsi_engine (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ifsi_pkg::cfg_t                      cfg,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  ifsi_pkg::packet_t                   in_pkt,
    output logic signed [ifsi_pkg::MUL_A_W-1:0] mul_a,
    output logic signed [ifsi_pkg::MUL_B_W-1:0] mul_b,
    input  logic signed [ifsi_pkg::PROD_W-1:0]  prod,
    output logic                                div_start,
    output logic [ifsi_pkg::DVD_W-1:0]          div_dividend,
    output logic [ifsi_pkg::STAMP_W-1:0]        div_divisor,
    input  logic                                div_done,
    input  logic [ifsi_pkg::DVD_W-1:0]          div_quot,
    output logic                                res_valid,
    input  logic                                res_take,
    output ifsi_pkg::result_t                   res
);
    import ifsi_pkg::*;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_MUL_AD   = 4'd1;
    localparam logic [3:0] ST_MUL_FB   = 4'd2;
    localparam logic [3:0] ST_SUM      = 4'd3;
    localparam logic [3:0] ST_MUL_GAIN = 4'd4;
    localparam logic [3:0] ST_SCALED   = 4'd5;
    localparam logic [3:0] ST_DIV      = 4'd6;
    localparam logic [3:0] ST_RAD_HI   = 4'd7;
    localparam logic [3:0] ST_RAD_LO   = 4'd8;
    localparam logic [3:0] ST_RAD_SUM  = 4'd9;
    localparam logic [3:0] ST_SAT      = 4'd10;
    localparam logic [3:0] ST_OUT      = 4'd11;

    localparam int Q_W = DVD_W - FRAC_DROP;

    logic [3:0]                    state_reg, state_next;
    logic [CH_IDX_W-1:0]           chan_reg, chan_next;
    logic [CH_N-1:0][SAMPLE_W-1:0] prev_reg, prev_next;
    logic [CH_N-1:0][SAMPLE_W-1:0] cur_reg;
    logic [STAMP_W-1:0]            stamp_reg;
    logic [TIME_W-1:0]             time_reg;
    logic [KIND_W-1:0]             kind_reg;
    logic [NUM_W-1:0]              acc_reg;
    logic [MAG_W-1:0]              mag_reg;
    logic                          neg_reg;
    logic [DVD_W-1:0]              t_reg;
    logic [CH_N-1:0][VAL_W-1:0]    work_reg;

    logic                  accept;
    logic                  is_normal;
    logic                  is_fsync;
    logic                  emit;
    logic [STAMP_W-1:0]    p_eff;
    logic [F_W-1:0]        f_val;
    logic [SAMPLE_W-1:0]   cur_sel;
    logic [SAMPLE_W-1:0]   prev_sel;
    logic                  is_gyro;
    logic                  to_rad;
    logic [GAIN_W-1:0]     gain_sel;
    logic [NUM_W-1:0]      sum;
    logic [NUM_W-1:0]      neg_sum;
    logic [Q_W-1:0]        q_val;
    logic                  q_big;
    logic [VAL_W-1:0]      sat_val;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign is_normal = (in_pkt.header == HDR_NORMAL);
    assign is_fsync  = (in_pkt.header == HDR_FSYNC);
    assign emit      = is_fsync || (cfg.raw_mode && is_normal);

    assign p_eff    = (cfg.sample_period == '0) ? STAMP_W'(1) : cfg.sample_period;
    assign f_val    = {1'b0, p_eff} - {1'b0, stamp_reg};
    assign cur_sel  = cur_reg[chan_reg];
    assign prev_sel = prev_reg[chan_reg];
    assign is_gyro  = (chan_reg >= CH_GYRO_FIRST);
    assign to_rad   = !cfg.raw_mode && is_gyro;
    assign gain_sel = is_gyro ? cfg.gyro_gain : cfg.accel_gain;

    assign sum     = acc_reg + prod[NUM_W-1:0];
    assign neg_sum = ~sum + 1'b1;

    assign q_val = t_reg[DVD_W-1:FRAC_DROP];
    assign q_big = |q_val[Q_W-1:VAL_W-1];

    always_comb begin
        if (neg_reg) begin
            sat_val = q_big ? VAL_MIN : (~q_val[VAL_W-1:0] + 1'b1);
        end else begin
            sat_val = q_big ? VAL_MAX : q_val[VAL_W-1:0];
        end
    end

    assign div_dividend = prod[DVD_W-1:0];
    assign div_divisor  = p_eff;

    always_comb begin
        state_next = state_reg;
        chan_next  = chan_reg;
        prev_next  = prev_reg;
        div_start  = 1'b0;
        res_valid  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (in_pkt.frame_start) begin
                        prev_next = '0;
                    end
                    if (!cfg.raw_mode && is_normal) begin
                        prev_next = in_pkt.sample;
                    end
                    if (emit) begin
                        chan_next  = '0;
                        state_next = ST_MUL_AD;
                    end
                end
            end
            // numerator n = a*d + f*b; raw mode runs s*1 + 0*0
            ST_MUL_AD: begin
                if (cfg.raw_mode) begin
                    mul_a = {{(MUL_A_W-SAMPLE_W){cur_sel[SAMPLE_W-1]}}, cur_sel};
                    mul_b = MUL_B_W'(1);
                end else begin
                    mul_a = {{(MUL_A_W-SAMPLE_W){prev_sel[SAMPLE_W-1]}}, prev_sel};
                    mul_b = {{(MUL_B_W-STAMP_W){1'b0}}, stamp_reg};
                end
                state_next = ST_MUL_FB;
            end
            ST_MUL_FB: begin
                if (!cfg.raw_mode) begin
                    mul_a = {{(MUL_A_W-F_W){f_val[F_W-1]}}, f_val};
                    mul_b = {{(MUL_B_W-SAMPLE_W){cur_sel[SAMPLE_W-1]}}, cur_sel};
                end
                state_next = ST_SUM;
            end
            ST_SUM: begin
                state_next = ST_MUL_GAIN;
            end
            ST_MUL_GAIN: begin
                mul_a      = {1'b0, mag_reg};
                mul_b      = {{(MUL_B_W-GAIN_W){1'b0}}, gain_sel};
                state_next = ST_SCALED;
            end
            ST_SCALED: begin
                if (cfg.raw_mode) begin
                    state_next = ST_SAT;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = to_rad ? ST_RAD_HI : ST_SAT;
                end
            end
            ST_RAD_HI: begin
                mul_a      = {{(MUL_A_W-(DVD_W-MAG_W)){1'b0}}, t_reg[DVD_W-1:MAG_W]};
                mul_b      = {{(MUL_B_W-K_W){1'b0}}, DEG2RAD_Q32};
                state_next = ST_RAD_LO;
            end
            ST_RAD_LO: begin
                mul_a      = {{(MUL_A_W-MAG_W){1'b0}}, t_reg[MAG_W-1:0]};
                mul_b      = {{(MUL_B_W-K_W){1'b0}}, DEG2RAD_Q32};
                state_next = ST_RAD_SUM;
            end
            ST_RAD_SUM: begin
                state_next = ST_SAT;
            end
            ST_SAT: begin
                if (chan_reg == CH_LAST) begin
                    state_next = ST_OUT;
                end else begin
                    chan_next  = chan_reg + 1'b1;
                    state_next = ST_MUL_AD;
                end
            end
            ST_OUT: begin
                res_valid = 1'b1;
                if (res_take) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            chan_reg  <= '0;
            prev_reg  <= '0;
        end else begin
            state_reg <= state_next;
            chan_reg  <= chan_next;
            prev_reg  <= prev_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cur_reg   <= in_pkt.sample;
            stamp_reg <= in_pkt.stamp;
            if (cfg.raw_mode) begin
                time_reg <= {{(TIME_W-STAMP_W){1'b0}}, in_pkt.stamp};
                kind_reg <= is_fsync ? KIND_RAW_FSYNC : KIND_RAW_NORMAL;
            end else begin
                time_reg <= in_pkt.camera_time;
                kind_reg <= KIND_FRAME;
            end
        end
        if (state_reg == ST_MUL_FB) begin
            acc_reg <= prod[NUM_W-1:0];
        end
        if (state_reg == ST_SUM) begin
            neg_reg <= sum[NUM_W-1];
            mag_reg <= sum[NUM_W-1] ? neg_sum[MAG_W-1:0] : sum[MAG_W-1:0];
        end
        if (state_reg == ST_SCALED) begin
            t_reg <= prod[DVD_W-1:0];
        end
        if (state_reg == ST_DIV && div_done) begin
            t_reg <= div_quot;
        end
        // high word times K lands first, the shifted low word product is added next
        if (state_reg == ST_RAD_LO) begin
            t_reg <= prod[DVD_W-1:0];
        end
        if (state_reg == ST_RAD_SUM) begin
            t_reg <= t_reg + {{(DVD_W-K_W){1'b0}}, prod[MAG_W +: K_W]};
        end
        if (state_reg == ST_SAT) begin
            work_reg[chan_reg] <= sat_val;
        end
    end

    assign res.kind     = kind_reg;
    assign res.time_out = time_reg;
    assign res.value    = work_reg;

endmodule

`default_nettype wire

### src/ifsi_checker.sv
// Port-level assertions for imu_fifo_fsync_interpolator_core, bound to the top.
// Depends on ifsi_pkg and imu_fifo_fsync_interpolator_core_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "imu_fifo_fsync_interpolator_core_macros.svh"

module ifsi_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [ifsi_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [ifsi_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic [ifsi_pkg::KIND_W-1:0]     m_tuser
);
    import ifsi_pkg::*;

    logic [HDR_W-1:0] in_hdr;
    logic             in_xfer;

    assign in_hdr  = s_tdata[S_HDR_LSB +: HDR_W];
    assign in_xfer = s_tvalid && s_tready;

    // an FSYNC packet always produces a result, so the input must close
    `IFSI_ASSERT_NEXT(a_fsync_busy, aclk, aresetn, in_xfer && (in_hdr == HDR_FSYNC), !s_tready, "FSYNC transfer did not stall input")

    // unknown headers are dropped without holding the input
    `IFSI_ASSERT_NEXT(a_ignored_free, aclk, aresetn, in_xfer && (in_hdr != HDR_FSYNC) && (in_hdr != HDR_NORMAL), s_tready, "ignored header stalled input")

    // raw results carry a 16-bit IMU stamp in time_out
    `IFSI_ASSERT_SAME(a_raw_stamp, aclk, aresetn, m_tvalid && (m_tuser != KIND_FRAME), m_tdata[TIME_W-1:STAMP_W] == '0, "raw result time_out wider than stamp")

    // a stalled result holds its payload
    `IFSI_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

endmodule

bind imu_fifo_fsync_interpolator_core ifsi_checker u_ifsi_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
